### src/mbet_pkg.sv
// Shared types, constants and helper functions for the Mandelbrot escape-time pixel block.
// Used by every module under src except mbet_checker; depends on nothing else.
package mbet_pkg;

    // Fixed-point format of coordinates and screen geometry.
    localparam int COORD_FRAC_BITS = 28;
    localparam int HALF_WIDTH      = 160;
    localparam int HALF_HEIGHT     = 120;

    localparam int COORD_W = 32;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int STEP_W  = 31;
    localparam int ITER_W  = 12;
    localparam int GRAY_W  = 5;
    localparam int COLOR_W = 16;

    // Signed pixel offset from the screen center; covers half sizes up to 4096.
    localparam int OFS_W  = 13;
    localparam int PRE_W  = OFS_W + STEP_W + 1;
    // Saturated squares never exceed the escape bound 4 << F.
    localparam int SQ_W   = COORD_FRAC_BITS + 3;
    localparam logic [63:0] ESC_BOUND = 64'd4 << COORD_FRAC_BITS;

    localparam int GRAY_MAX = 31;
    localparam int DIVD_W   = ITER_W + GRAY_W;
    localparam int DCNT_W   = $clog2(DIVD_W + 1);

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Register reset values.
    localparam logic signed [COORD_W-1:0] CENTER_RE_RST  = -32'sd63117224;
    localparam logic signed [COORD_W-1:0] CENTER_IM_RST  = 32'sd222055706;
    localparam logic [STEP_W-1:0]         PIXEL_STEP_RST = 31'd11190;
    localparam logic [ITER_W-1:0]         MAX_ITER_RST   = 12'd51;

    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_CENTER_RE,
        REG_CENTER_IM,
        REG_PIXEL_STEP,
        REG_MAX_ITER
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CADD,
        ST_UPD,
        ST_SQ,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_pix;   // capture pixel offsets
        logic mul_c;      // form offset * step products
        logic init;       // form c and clear the orbit
        logic step;       // one orbit update z <- z*z + c
        logic square;     // register the three products of the new z
        logic div_start;  // start the gray-level division
        logic out_load;   // load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic stop;       // escaped or limit reached
        logic div_done;
        logic out_free;
    } ctrl_stat_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX)
            return 32'sh7FFF_FFFF;
        else if (v < S32_MIN)
            return 32'sh8000_0000;
        else
            return v[COORD_W-1:0];
    endfunction

    // Square in F-fraction format, clamped at the escape bound.
    function automatic logic [SQ_W-1:0] sq_sat(input logic signed [63:0] p);
        logic [63:0] sh;
        sh = $unsigned(p) >> COORD_FRAC_BITS;
        if (sh > ESC_BOUND)
            return SQ_W'(ESC_BOUND);
        else
            return SQ_W'(sh);
    endfunction

endpackage

### src/mbet_div.sv
// Restoring divider, one quotient bit per cycle, for the gray-level ratio.
// Depends on mbet_pkg.
module mbet_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mbet_pkg::DIVD_W-1:0]  dividend,
    input  logic [mbet_pkg::ITER_W-1:0]  divisor,
    output logic                         done,
    output logic [mbet_pkg::DIVD_W-1:0]  quotient
);
    import mbet_pkg::*;

    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [ITER_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [ITER_W-1:0] dsr_reg, dsr_next;
    logic [ITER_W:0]   shifted;
    logic [ITER_W:0]   diff;
    logic              fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVD_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = DCNT_W'(DIVD_W);
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? diff[ITER_W-1:0] : shifted[ITER_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

### src/mbet_dpath.sv
// Datapath: pixel-to-plane mapping, orbit registers and multipliers, result register.
// Depends on mbet_pkg and mbet_div.
module mbet_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mbet_pkg::ctrl_cmd_t                 cmd,
    output mbet_pkg::ctrl_stat_t                stat,
    input  logic signed [mbet_pkg::COORD_W-1:0] center_re,
    input  logic signed [mbet_pkg::COORD_W-1:0] center_im,
    input  logic [mbet_pkg::STEP_W-1:0]         pixel_step,
    input  logic [mbet_pkg::ITER_W-1:0]         max_iter,
    input  logic [mbet_pkg::COL_W-1:0]          pixel_col,
    input  logic [mbet_pkg::ROW_W-1:0]          pixel_row,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [mbet_pkg::ITER_W-1:0]         iter_count,
    output logic [mbet_pkg::GRAY_W-1:0]         gray_level,
    output logic [mbet_pkg::COLOR_W-1:0]        pixel_color
);
    import mbet_pkg::*;

    logic signed [OFS_W-1:0]   col_ofs_reg, row_ofs_reg;
    logic signed [PRE_W-1:0]   pre_re_reg, pre_im_reg;
    logic signed [COORD_W-1:0] c_re_reg, c_im_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic signed [63:0]        pxx_reg, pyy_reg, pxy_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [ITER_W-1:0]         iter_count_reg;
    logic [GRAY_W-1:0]         gray_level_reg;

    logic [SQ_W-1:0]           x2, y2;
    logic [SQ_W:0]             mag;
    logic signed [63:0]        x_sum, y_sum;
    logic [DIVD_W-1:0]         dividend;
    logic [DIVD_W-1:0]         quotient;
    logic                      div_done;
    logic [GRAY_W-1:0]         gray;

    // Squares and cross term of the current z come from the product registers.
    always_comb
    begin
        x2    = sq_sat(pxx_reg);
        y2    = sq_sat(pyy_reg);
        mag   = {1'b0, x2} + {1'b0, y2};
        x_sum = 64'(c_re_reg) + $signed(64'(x2)) - $signed(64'(y2));
        y_sum = 64'(c_im_reg) + (pxy_reg >>> (COORD_FRAC_BITS - 1));
    end

    assign dividend = DIVD_W'(iter_reg) * DIVD_W'(GRAY_MAX);

    mbet_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (max_iter),
        .done     (div_done),
        .quotient (quotient)
    );

    assign gray = (max_iter == '0) ? '0 : quotient[GRAY_W-1:0];

    always_comb
    begin
        stat.stop     = (mag >= (SQ_W+1)'(ESC_BOUND)) || (iter_reg >= max_iter);
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            col_ofs_reg <= OFS_W'(pixel_col) - OFS_W'(HALF_WIDTH);
            row_ofs_reg <= OFS_W'(pixel_row) - OFS_W'(HALF_HEIGHT);
        end
        if (cmd.mul_c)
        begin
            pre_re_reg <= col_ofs_reg * $signed({1'b0, pixel_step});
            pre_im_reg <= row_ofs_reg * $signed({1'b0, pixel_step});
        end
        if (cmd.init)
        begin
            c_re_reg <= sat32(64'(pre_re_reg) + 64'(center_re));
            c_im_reg <= sat32(64'(pre_im_reg) + 64'(center_im));
            x_reg    <= '0;
            y_reg    <= '0;
            pxx_reg  <= '0;
            pyy_reg  <= '0;
            pxy_reg  <= '0;
            iter_reg <= '0;
        end
        else if (cmd.step)
        begin
            x_reg    <= sat32(x_sum);
            y_reg    <= sat32(y_sum);
            iter_reg <= iter_reg + 1'b1;
        end
        else if (cmd.square)
        begin
            pxx_reg <= x_reg * x_reg;
            pyy_reg <= y_reg * y_reg;
            pxy_reg <= x_reg * y_reg;
        end
        if (cmd.out_load)
        begin
            iter_count_reg <= iter_reg;
            gray_level_reg <= gray;
        end
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid   = out_valid_reg;
    assign iter_count  = iter_count_reg;
    assign gray_level  = gray_level_reg;
    assign pixel_color = {gray_level_reg, 1'b0, gray_level_reg, gray_level_reg};

endmodule

### src/mbet_ctrl.sv
// Controller state machine: sequences mapping, orbit iterations, division and output.
// Depends on mbet_pkg.
module mbet_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mbet_pkg::ctrl_stat_t  stat,
    output mbet_pkg::ctrl_cmd_t   cmd
);
    import mbet_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_CMUL;
            ST_CMUL: state_next = ST_CADD;
            ST_CADD: state_next = ST_UPD;
            ST_UPD:  state_next = stat.stop ? ST_DIV : ST_SQ;
            ST_SQ:   state_next = ST_UPD;
            ST_DIV:  if (stat.div_done) state_next = ST_OUT;
            ST_OUT:  if (stat.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_pix = in_valid;
            end
            ST_CMUL: cmd.mul_c = 1'b1;
            ST_CADD: cmd.init  = 1'b1;
            ST_UPD:
            begin
                cmd.div_start = stat.stop;
                cmd.step      = !stat.stop;
            end
            ST_SQ:   cmd.square   = 1'b1;
            ST_DIV:  cmd.out_load = 1'b0;
            ST_OUT:  cmd.out_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### src/mandelbrot_escape_time_pixel.sv
// Top level of the Mandelbrot escape-time pixel block: configuration registers and
// the controller and datapath. Depends on mbet_pkg, mbet_ctrl, mbet_dpath.
//
// Each accepted pixel (column, row) is mapped to c in Q4.28, iterated as z <- z*z + c
// until |z|^2 reaches 4 or max_iter iterations are done, and returned as the
// iteration count, a 5-bit gray level and an RGB565 gray pixel. One pixel is in
// flight at a time. Each iteration uses the three 32x32 multipliers in the square
// step and the adders in the add and escape-test step, and the gray level comes
// from a serial divider. A new pixel is taken while the previous result still
// waits in the output register. Registers sit at byte addresses 0 (center_re),
// 4 (center_im), 8 (pixel_step) and 12 (max_iter) and are to be written only while
// the block is idle.
module mandelbrot_escape_time_pixel (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbet_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mbet_pkg::COL_W-1:0]          pixel_col,
    input  logic [mbet_pkg::ROW_W-1:0]          pixel_row,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mbet_pkg::ITER_W-1:0]         iter_count,
    output logic [mbet_pkg::GRAY_W-1:0]         gray_level,
    output logic [mbet_pkg::COLOR_W-1:0]        pixel_color
);
    import mbet_pkg::*;

    logic signed [COORD_W-1:0] center_re_reg, center_im_reg;
    logic [STEP_W-1:0]         pixel_step_reg;
    logic [ITER_W-1:0]         max_iter_reg;
    logic                      wr_en;
    reg_idx_t                  reg_idx;
    ctrl_cmd_t                 cmd;
    ctrl_stat_t                stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_re_reg  <= CENTER_RE_RST;
            center_im_reg  <= CENTER_IM_RST;
            pixel_step_reg <= PIXEL_STEP_RST;
            max_iter_reg   <= MAX_ITER_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CENTER_RE:  center_re_reg  <= pwdata;
                REG_CENTER_IM:  center_im_reg  <= pwdata;
                REG_PIXEL_STEP: pixel_step_reg <= pwdata[STEP_W-1:0];
                REG_MAX_ITER:   max_iter_reg   <= pwdata[ITER_W-1:0];
                default:        max_iter_reg   <= max_iter_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER_RE:  prdata = center_re_reg;
            REG_CENTER_IM:  prdata = center_im_reg;
            REG_PIXEL_STEP: prdata = 32'(pixel_step_reg);
            REG_MAX_ITER:   prdata = 32'(max_iter_reg);
            default:        prdata = '0;
        endcase
    end

    mbet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbet_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .center_re   (center_re_reg),
        .center_im   (center_im_reg),
        .pixel_step  (pixel_step_reg),
        .max_iter    (max_iter_reg),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .iter_count  (iter_count),
        .gray_level  (gray_level),
        .pixel_color (pixel_color)
    );

endmodule

### src/mbet_checker.sv
// Port-level assertions for the Mandelbrot escape-time pixel block, bound to the top level.
// Depends only on the top-level port list.
module mbet_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] iter_count,
    input logic [4:0]  gray_level,
    input logic [15:0] pixel_color
);

    // A result held back by the consumer keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(iter_count)
            && $stable(gray_level) && $stable(pixel_color))
    else $error("stalled result changed");

    // The color word carries the gray level in all three channels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixel_color == {gray_level, 1'b0, gray_level, gray_level})
    else $error("pixel color does not match gray level");

    // A pixel that did no iterations is black.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && iter_count == 12'd0 |-> gray_level == 5'd0)
    else $error("nonzero gray for zero iterations");

    // Only one pixel is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second pixel taken while one is in work");

endmodule

bind mandelbrot_escape_time_pixel mbet_checker u_mbet_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .iter_count  (iter_count),
    .gray_level  (gray_level),
    .pixel_color (pixel_color)
);
